// File: hdl/lppe_pkg.sv
// Package for the LED pixel pulse encoder: constants, register and function codes.
// It has no dependencies and is used by the top level and its checker.
package lppe_pkg;

	localparam int RESET_SLOTS    = 50;
	localparam int BITS_PER_PIXEL = 24;
	localparam int MAX_SLOTS      = (RESET_SLOTS > BITS_PER_PIXEL) ? RESET_SLOTS : BITS_PER_PIXEL;
	localparam int CNT_W          = $clog2(MAX_SLOTS);
	localparam int APB_AW         = 4;
	localparam int APB_DW         = 32;

	localparam logic [CNT_W-1:0] PIXEL_LAST_CNT = CNT_W'(BITS_PER_PIXEL - 1);
	localparam logic [CNT_W-1:0] RESET_LAST_CNT = CNT_W'(RESET_SLOTS - 1);

	localparam logic [7:0] BRIGHTNESS_RST = 8'd128;
	localparam logic [7:0] ZERO_TICKS_RST = 8'd35;
	localparam logic [7:0] ONE_TICKS_RST  = 8'd70;

	typedef enum logic [1:0] {
		REG_BRIGHTNESS = 2'd0,
		REG_ZERO_TICKS = 2'd1,
		REG_ONE_TICKS  = 2'd2
	} reg_idx_t;

	typedef enum logic {
		FUNC_PIXEL     = 1'b0,
		FUNC_FRAME_END = 1'b1
	} func_t;

	function automatic logic [7:0] scale_channel(input logic [7:0] c, input logic [7:0] br);
		logic [15:0] prod;
		prod = 16'(c) * 16'(br);
		return prod[15:8];
	endfunction

endpackage

// File: hdl/led_pixel_pulse_encoder.sv
// Pipeline: an item is taken into the input register (valid_s1, color_s1) and then
// loaded into the serialiser (busy_q, shift_q), which drives the result outputs.
// Throughput: one result per cycle while m_tready is high; a pixel is emitted as 24 bit
// slots and a frame end as RESET_SLOTS slots, counted by the bit-slot down-counter.
// An input register takes the next item while the current one is still being emitted.
// Reset is asynchronous and active low; it empties both stages and restores the registers
// to brightness 128, zero high time 35 and one high time 70.
module led_pixel_pulse_encoder
	import lppe_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [23:0]       s_tdata,   // color[23:0]
	input  logic              s_tuser,   // func[0]
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [7:0]        m_tdata,   // pulse_ticks[7:0]
	output logic              m_tlast,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	logic [7:0]       brightness_q;
	logic [7:0]       zero_ticks_q;
	logic [7:0]       one_ticks_q;
	logic             cfg_wr;
	reg_idx_t         cfg_idx;

	logic             valid_s1;
	func_t            func_s1;
	logic [23:0]      color_s1;

	logic             busy_q;
	func_t            func_q;
	logic [23:0]      shift_q;
	logic [CNT_W-1:0] cnt_q;

	logic             load;
	logic [23:0]      grb;

	assign pready  = 1'b1;
	assign cfg_idx = reg_idx_t'(paddr[3:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			brightness_q <= BRIGHTNESS_RST;
			zero_ticks_q <= ZERO_TICKS_RST;
			one_ticks_q  <= ONE_TICKS_RST;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_BRIGHTNESS: brightness_q <= pwdata[7:0];
				REG_ZERO_TICKS: zero_ticks_q <= pwdata[7:0];
				REG_ONE_TICKS:  one_ticks_q  <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_BRIGHTNESS: prdata = {{(APB_DW-8){1'b0}}, brightness_q};
			REG_ZERO_TICKS: prdata = {{(APB_DW-8){1'b0}}, zero_ticks_q};
			REG_ONE_TICKS:  prdata = {{(APB_DW-8){1'b0}}, one_ticks_q};
			default:        prdata = '0;
		endcase
	end

	assign m_tlast  = (cnt_q == '0);
	assign load     = valid_s1 && (!busy_q || (m_tready && m_tlast));
	assign s_tready = !valid_s1 || load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (load) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			func_s1  <= func_t'(s_tuser);
			color_s1 <= s_tdata;
		end
	end

	// The output order is green, red, blue, most significant bit first.
	assign grb = {scale_channel(color_s1[15:8], brightness_q),
		scale_channel(color_s1[23:16], brightness_q),
		scale_channel(color_s1[7:0], brightness_q)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			cnt_q  <= (func_s1 == FUNC_FRAME_END) ? RESET_LAST_CNT : PIXEL_LAST_CNT;
		end else if (busy_q && m_tready) begin
			if (m_tlast) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			func_q  <= func_s1;
			shift_q <= grb;
		end else if (busy_q && m_tready) begin
			shift_q <= {shift_q[22:0], 1'b0};
		end
	end

	assign m_tvalid = busy_q;
	assign m_tdata  = (func_q == FUNC_FRAME_END) ? 8'd0 :
		(shift_q[23] ? one_ticks_q : zero_ticks_q);

endmodule

// File: hdl/lppe_checker.sv
// Port-level checker for the LED pixel pulse encoder, bound to the top level.
// It depends on lppe_pkg for the port widths.
module lppe_checker
	import lppe_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              s_tready,
	input logic              m_tvalid,
	input logic              m_tready,
	input logic [7:0]        m_tdata,
	input logic              m_tlast,
	input logic              psel,
	input logic              penable,
	input logic              pwrite,
	input logic [APB_AW-1:0] paddr,
	input logic [APB_DW-1:0] pwdata,
	input logic [APB_DW-1:0] prdata,
	input logic              pready
);

	// A stalled result transaction keeps its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result changed while stalled");

	// The input side only stalls while a result is pending.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with no pending result");

	// A brightness write is read back in the following cycle.
	a_cfg_readback: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && pwrite && pready && paddr[3:2] == REG_BRIGHTNESS)
		##1 (paddr[3:2] == REG_BRIGHTNESS)
		|-> prdata == {{(APB_DW-8){1'b0}}, $past(pwdata[7:0])})
		else $error("brightness read-back mismatch");

endmodule

bind led_pixel_pulse_encoder lppe_checker u_lppe_checker (.*);
